// ===== sv/tcce_pkg.sv =====
`timescale 1ns / 1ps

package tcce_pkg;

  typedef enum logic [1:0] {
    OP_PUT_CHAR        = 2'd0,
    OP_READ_CELL       = 2'd1,
    OP_CLEAR_SCREEN    = 2'd2,
    OP_CLEAR_BELOW_TOP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_LEFT_COLUMN  = 2'd0,
    CFG_RIGHT_COLUMN = 2'd1,
    CFG_BOTTOM_ROW   = 2'd2,
    CFG_TEXT_ATTR    = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_SCROLL,
    ST_PUTC,
    ST_FILL,
    ST_READ,
    ST_READ_WAIT,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    MEM_IDLE,
    MEM_FILL_BLANK,
    MEM_FILL_ATTR,
    MEM_SCROLL,
    MEM_PUTC,
    MEM_READ
  } mem_op_e;

  localparam logic [7:0]  CHAR_BS    = 8'h08;
  localparam logic [7:0]  CHAR_TAB   = 8'h09;
  localparam logic [7:0]  CHAR_LF    = 8'h0A;
  localparam logic [7:0]  CHAR_CR    = 8'h0D;
  localparam logic [7:0]  CHAR_SPACE = 8'h20;
  localparam logic [7:0]  FILL_CHAR  = 8'd219;
  localparam logic [7:0]  TAB_STEP   = 8'd4;
  localparam logic [15:0] BLANK_CELL = 16'h0720;

  typedef struct packed {
    logic    capture;
    logic    decode;
    logic    cnt_load;
    logic    cnt_inc;
    mem_op_e mem_op;
    logic    capture_read;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic plan_scroll;
    logic plan_write;
    logic fill_last;
    logic scroll_last;
  } sts_t;

endpackage

// ===== sv/tcce_in_if.sv =====
`timescale 1ns / 1ps

interface tcce_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  char_code;
  logic [10:0] cell_index;
  logic [7:0]  fill_attr;

  modport source (output valid, op, char_code, cell_index, fill_attr, input ready);
  modport sink (input valid, op, char_code, cell_index, fill_attr, output ready);
endinterface

// ===== sv/tcce_out_if.sv =====
`timescale 1ns / 1ps

interface tcce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_char;
  logic [7:0] cell_attr;
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;
  logic       scrolled;
  logic       written;

  modport source (output valid, cell_char, cell_attr, cursor_col, cursor_row, scrolled,
                  written, input ready);
  modport sink (input valid, cell_char, cell_attr, cursor_col, cursor_row, scrolled,
                written, output ready);
endinterface

// ===== sv/tcce_ram.sv =====
`timescale 1ns / 1ps

module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tcce_ctrl.sv =====
`timescale 1ns / 1ps

module tcce_ctrl
  import tcce_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mem_op = MEM_IDLE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        // Blank the whole cell store once after reset.
        cmd_o.mem_op  = MEM_FILL_BLANK;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.fill_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode   = 1'b1;
        cmd_o.cnt_load = 1'b1;
        unique case (sts_i.op)
          OP_PUT_CHAR: begin
            if (sts_i.plan_scroll) begin
              state_d = ST_SCROLL;
            end else if (sts_i.plan_write) begin
              state_d = ST_PUTC;
            end else begin
              state_d = ST_FINISH;
            end
          end
          OP_READ_CELL:                        state_d = ST_READ;
          OP_CLEAR_SCREEN, OP_CLEAR_BELOW_TOP: state_d = ST_FILL;
          default:                             state_d = ST_FINISH;
        endcase
      end
      ST_SCROLL: begin
        cmd_o.mem_op  = MEM_SCROLL;
        cmd_o.cnt_inc = 1'b1;
        // After a scroll the cursor row is always inside the store.
        if (sts_i.scroll_last) begin
          state_d = ST_PUTC;
        end
      end
      ST_PUTC: begin
        cmd_o.mem_op = MEM_PUTC;
        state_d      = ST_FINISH;
      end
      ST_FILL: begin
        cmd_o.mem_op  = MEM_FILL_ATTR;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.fill_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_READ: begin
        cmd_o.mem_op = MEM_READ;
        state_d      = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        cmd_o.capture_read = 1'b1;
        state_d            = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  assign out_valid_d = cmd_o.load_out | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/tcce_dpath.sv =====
`timescale 1ns / 1ps

module tcce_dpath
  import tcce_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  char_code_i,
  input  logic [10:0] cell_index_i,
  input  logic [7:0]  fill_attr_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  output logic [7:0]  cell_char_o,
  output logic [7:0]  cell_attr_o,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_row_o,
  output logic        scrolled_o,
  output logic        written_o
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int NW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int BW    = (RW > 5) ? RW : 5;
  localparam int PW    = RW + 8;
  localparam int IXW   = (NW > 11) ? NW : 11;

  function automatic logic [6:0] sat_col(input logic [7:0] c);
    sat_col = (c > 8'(COLS - 1)) ? 7'(COLS - 1) : c[6:0];
  endfunction

  function automatic logic [RW-1:0] next_row(input logic [RW-1:0] r);
    next_row = (r >= RW'(ROWS)) ? RW'(ROWS) : r + RW'(1);
  endfunction

  // Configuration registers.
  logic [6:0] left_q, right_q;
  logic [4:0] bottom_q;
  logic [7:0] tattr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= 7'd0;
      right_q  <= 7'd80;
      bottom_q <= 5'd24;
      tattr_q  <= 8'd7;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LEFT_COLUMN:  left_q   <= cfg_data_i[6:0];
        CFG_RIGHT_COLUMN: right_q  <= cfg_data_i[6:0];
        CFG_BOTTOM_ROW:   bottom_q <= cfg_data_i[4:0];
        CFG_TEXT_ATTR:    tattr_q  <= cfg_data_i;
        default:          left_q   <= left_q;
      endcase
    end
  end

  // Item registers.
  op_e         op_q;
  logic [7:0]  ch_q, fattr_q;
  logic [10:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_e'(op_i);
      ch_q    <= char_code_i;
      idx_q   <= cell_index_i;
      fattr_q <= fill_attr_i;
    end
  end

  // Cursor state.
  logic [6:0]    col_q, nxt_col;
  logic [RW-1:0] row_q, nxt_row;
  logic [7:0]    prev_q, nxt_prev;

  logic [7:0]    col8;
  logic [6:0]    left_sat, pc_col;
  logic          wrap, pc_scroll, pc_write;
  logic [RW-1:0] pc_row0, pc_row;
  logic [PW-1:0] lin;
  logic          plan_scroll, plan_write, res_wr;

  assign col8      = {1'b0, col_q};
  assign left_sat  = sat_col({1'b0, left_q});
  assign wrap      = (col8 + 8'd1) >= {1'b0, right_q};
  assign pc_col    = wrap ? left_sat : sat_col(col8 + 8'd1);
  assign pc_row0   = wrap ? next_row(row_q) : row_q;
  assign pc_scroll = BW'(pc_row0) > BW'(bottom_q);
  // A scroll only happens when the bottom row lies inside the store.
  assign pc_row    = pc_scroll ? RW'(bottom_q) : pc_row0;
  assign pc_write  = pc_row < RW'(ROWS);
  assign lin       = PW'(pc_row) * PW'(COLS) + PW'(pc_col);

  always_comb begin
    nxt_col     = col_q;
    nxt_row     = row_q;
    nxt_prev    = prev_q;
    plan_scroll = 1'b0;
    plan_write  = 1'b0;
    res_wr      = 1'b0;
    unique case (op_q)
      OP_PUT_CHAR: begin
        if (ch_q == CHAR_CR) begin
          nxt_col  = left_sat;
          nxt_prev = ch_q;
        end else if (ch_q == CHAR_LF) begin
          nxt_row = next_row(row_q);
          if (prev_q != CHAR_CR) begin
            nxt_col = left_sat;
          end
          nxt_prev = ch_q;
        end else if (ch_q == CHAR_TAB) begin
          nxt_col  = sat_col(col8 + TAB_STEP);
          nxt_prev = ch_q;
        end else if (ch_q == CHAR_SPACE) begin
          nxt_col  = sat_col(col8 + 8'd1);
          nxt_prev = ch_q;
        end else if (ch_q == CHAR_BS) begin
          nxt_col  = (col_q != 7'd0) ? col_q - 7'd1 : 7'd0;
          nxt_prev = ch_q;
        end else if (ch_q > CHAR_SPACE) begin
          nxt_col     = pc_col;
          nxt_row     = pc_row;
          plan_scroll = pc_scroll;
          plan_write  = pc_write;
          res_wr      = pc_write;
          nxt_prev    = ch_q;
        end else begin
          // Other control bytes leave the cursor and the last byte alone.
          nxt_prev = prev_q;
        end
      end
      OP_READ_CELL: begin
        nxt_prev = prev_q;
      end
      OP_CLEAR_SCREEN, OP_CLEAR_BELOW_TOP: begin
        nxt_col = 7'd0;
        nxt_row = '0;
        res_wr  = 1'b1;
      end
      default: nxt_prev = prev_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= 7'd0;
      row_q  <= '0;
      prev_q <= 8'd0;
    end else if (cmd_i.decode) begin
      col_q  <= nxt_col;
      row_q  <= nxt_row;
      prev_q <= nxt_prev;
    end
  end

  // Result staging.
  logic [AW-1:0] waddr_q;
  logic          res_scroll_q, res_wr_q;
  logic [7:0]    res_char_q, res_attr_q;
  logic [15:0]   rd_data;
  logic          rd_in_range;

  assign rd_in_range = IXW'(idx_q) < IXW'(CELLS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      waddr_q      <= lin[AW-1:0];
      res_scroll_q <= plan_scroll;
      res_wr_q     <= res_wr;
      res_char_q   <= 8'd0;
      res_attr_q   <= 8'd0;
    end else if (cmd_i.capture_read && rd_in_range) begin
      res_char_q <= rd_data[7:0];
      res_attr_q <= rd_data[15:8];
    end
  end

  // Sweep counter for the reset pass, clears and scrolls.
  logic [NW-1:0] cnt_q;
  logic [NW-1:0] cnt_first;

  assign cnt_first = (op_q == OP_CLEAR_BELOW_TOP) ? NW'(COLS) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_load) begin
      cnt_q <= cnt_first;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + NW'(1);
    end
  end

  // Cell store ports.
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata;
  logic [NW-1:0] cnt_up, cnt_dn;

  assign cnt_up = cnt_q + NW'(COLS);
  assign cnt_dn = cnt_q - NW'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = cnt_q[AW-1:0];
    mem_raddr = cnt_up[AW-1:0];
    mem_wdata = BLANK_CELL;
    unique case (cmd_i.mem_op)
      MEM_IDLE: mem_we = 1'b0;
      MEM_FILL_BLANK: mem_we = 1'b1;
      MEM_FILL_ATTR: begin
        mem_we    = 1'b1;
        mem_wdata = {fattr_q, FILL_CHAR};
      end
      MEM_SCROLL: begin
        // Read one row ahead and write the row above in the next cycle, once the RAM read data is
        // registered; the last row gets blanks once the copy runs out.
        mem_re    = cnt_q < NW'(CELLS - COLS);
        mem_we    = cnt_q != '0;
        mem_waddr = cnt_dn[AW-1:0];
        mem_wdata = (cnt_q <= NW'(CELLS - COLS)) ? rd_data : BLANK_CELL;
      end
      MEM_PUTC: begin
        mem_we    = 1'b1;
        mem_waddr = waddr_q;
        mem_wdata = {tattr_q, ch_q};
      end
      MEM_READ: begin
        mem_re    = rd_in_range;
        mem_raddr = AW'(idx_q);
      end
      default: mem_we = 1'b0;
    endcase
  end

  tcce_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_cells (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(rd_data)
  );

  assign sts_o.op          = op_q;
  assign sts_o.plan_scroll = plan_scroll;
  assign sts_o.plan_write  = plan_write;
  assign sts_o.fill_last   = cnt_q == NW'(CELLS - 1);
  assign sts_o.scroll_last = cnt_q == NW'(CELLS);

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      cell_char_o  <= res_char_q;
      cell_attr_o  <= res_attr_q;
      cursor_col_o <= col_q;
      cursor_row_o <= 5'(row_q);
      scrolled_o   <= res_scroll_q;
      written_o    <= res_wr_q;
    end
  end

endmodule

// ===== sv/text_console_cursor_engine_top.sv =====
`timescale 1ns / 1ps
// Each item passes through the control states in order: cursor bytes go through decode and
// finish; a printed byte that lands inside the store adds a cell write; a cell read adds a
// read and a read wait; a printed byte that scrolls first sweeps the whole cell store, and
// the clears sweep it (from the second row when the top row is kept), one cell per cycle
// over the cell store's single write port. One item is in work at a time. After reset a
// blanking pass over every cell holds the input not ready; the configuration port takes writes throughout.
module text_console_cursor_engine_top
  import tcce_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcce_in_if.sink    in_i,
  tcce_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready, out_valid;

  tcce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .out_ready_i(out_o.ready),
    .out_valid_o(out_valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcce_dpath #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (in_i.op),
    .char_code_i (in_i.char_code),
    .cell_index_i(in_i.cell_index),
    .fill_attr_i (in_i.fill_attr),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cell_char_o (out_o.cell_char),
    .cell_attr_o (out_o.cell_attr),
    .cursor_col_o(out_o.cursor_col),
    .cursor_row_o(out_o.cursor_row),
    .scrolled_o  (out_o.scrolled),
    .written_o   (out_o.written)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule
